### hw/rtl/segmented_sum_capped_stack_assert.svh
// Assertion macros used by the segmented sum-capped stack top level.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SEGMENTED_SUM_CAPPED_STACK_ASSERT_SVH
`define SEGMENTED_SUM_CAPPED_STACK_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSCS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### hw/rtl/sscs_pkg.sv
`timescale 1ns / 1ps
// Package for the segmented sum-capped stack: widths, defaults, codes and types.
// Used by sscs_cell, sscs_store and segmented_sum_capped_stack.
package sscs_pkg;

  localparam int unsigned VALUE_W          = 16;
  localparam int unsigned SEG_CNT_W        = 5;
  localparam int unsigned STATUS_W         = 2;
  localparam int unsigned DEF_STACK_DEPTH  = 256;
  localparam int unsigned DEF_MAX_SEGMENTS = 16;
  localparam logic [VALUE_W-1:0] DEF_CAPACITY = 16'd1000;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // What a segment cell does at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_UPPER,
    CELL_TAKE_LOWER
  } cell_cmd_t;

  // Commands for the chain: the top cell has its own, the rest share one.
  typedef struct packed {
    cell_cmd_t top_cmd;
    cell_cmd_t rest_cmd;
  } chain_ctl_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } sscs_state_t;

endpackage

### hw/rtl/sscs_cell.sv
`timescale 1ns / 1ps
// One segment cell: holds a segment's running sum and base index.
// Depends on sscs_pkg for the command type and value width.
module sscs_cell #(
  parameter int unsigned BASE_W = 9
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sscs_pkg::cell_cmd_t               cmd,
  input  logic [sscs_pkg::VALUE_W-1:0]      up_sum,
  input  logic [BASE_W-1:0]                 up_base,
  input  logic [sscs_pkg::VALUE_W-1:0]      dn_sum,
  input  logic [BASE_W-1:0]                 dn_base,
  output logic [sscs_pkg::VALUE_W-1:0]      sum,
  output logic [BASE_W-1:0]                 base
);
  import sscs_pkg::*;

  logic [VALUE_W-1:0] sum_r, sum_nxt;
  logic [BASE_W-1:0]  base_r, base_nxt;

  always_comb begin
    sum_nxt  = sum_r;
    base_nxt = base_r;
    case (cmd)
      CELL_TAKE_UPPER: begin
        sum_nxt  = up_sum;
        base_nxt = up_base;
      end
      CELL_TAKE_LOWER: begin
        sum_nxt  = dn_sum;
        base_nxt = dn_base;
      end
      default: begin
        sum_nxt  = sum_r;
        base_nxt = base_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      base_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      base_r <= base_nxt;
    end
  end

  assign sum  = sum_r;
  assign base = base_r;

endmodule

### hw/rtl/sscs_store.sv
`timescale 1ns / 1ps
// Value store of the stack: single write port, registered read port.
// Depends on sscs_pkg for the value width.
module sscs_store #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  logic [sscs_pkg::VALUE_W-1:0]  wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(DEPTH)-1:0]      rd_addr,
  output logic [sscs_pkg::VALUE_W-1:0]  rd_data
);
  import sscs_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/segmented_sum_capped_stack.sv
`timescale 1ns / 1ps
// Top level of the segmented sum-capped stack: control, segment cell chain, value store.
// Depends on sscs_pkg, sscs_cell, sscs_store and the assertion macro header.
`include "segmented_sum_capped_stack_assert.svh"
// Usage:
// The input channel (in_valid / in_stall) carries one transaction per operation:
// in_opcode selects push or pop and in_energy_value is the value to push.
// Each accepted transaction produces exactly one result transaction on the
// output channel (out_valid / out_stall) with the popped value, the segment
// count, the top segment's sum and a status code.
// The cfg channel (cfg_valid / cfg_ready) writes the segment capacity; it is
// only ready while no operation is in flight.
// An operation has an accept cycle and an update cycle: the accept cycle issues
// the read of the top value from the value store, and the update cycle updates
// the count, the store and the segment cell chain and loads the output register.
// The result is visible the cycle after that. A new transaction is accepted only
// after the operation in progress has committed, due to the dependence through
// the store's registered read. If the receiver stalls while a result is still
// held, the operation in progress waits in its update cycle until the output
// register frees up. Reset empties the stack, leaves one segment with sum zero
// and sets the capacity to 1000; the store itself is not cleared.
module segmented_sum_capped_stack #(
  parameter int unsigned STACK_DEPTH  = sscs_pkg::DEF_STACK_DEPTH,
  parameter int unsigned MAX_SEGMENTS = sscs_pkg::DEF_MAX_SEGMENTS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_opcode,
  input  logic [sscs_pkg::VALUE_W-1:0]     in_energy_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [sscs_pkg::VALUE_W-1:0]     out_popped_value,
  output logic [sscs_pkg::SEG_CNT_W-1:0]   out_segment_count,
  output logic [sscs_pkg::VALUE_W-1:0]     out_top_sum,
  output logic [sscs_pkg::STATUS_W-1:0]    out_status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sscs_pkg::VALUE_W-1:0]     cfg_data
);
  import sscs_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned SW = $clog2(MAX_SEGMENTS);

  sscs_state_t state_r, state_nxt;

  logic               op_r;
  logic [VALUE_W-1:0] val_r;
  logic [VALUE_W-1:0] cap_r, cap_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [SW-1:0]      top_r, top_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]   popped_r, popped_nxt;
  logic [SEG_CNT_W-1:0] seg_cnt_r, seg_cnt_nxt;
  logic [VALUE_W-1:0]   top_sum_r, top_sum_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;

  logic in_accept;
  logic commit;
  logic rd_en;

  // Segment cell chain: cell 0 is the top segment.
  logic [VALUE_W-1:0] cell_sum  [MAX_SEGMENTS];
  logic [CW-1:0]      cell_base [MAX_SEGMENTS];
  logic [VALUE_W-1:0] new_sum;
  logic [CW-1:0]      new_base;
  chain_ctl_t         chain_ctl;

  logic [VALUE_W-1:0] rd_data;
  logic [CW-1:0]      cnt_m1;
  logic               wr_en;

  logic [VALUE_W:0]   push_total;
  logic               push_open;
  logic               push_drop;
  logic               pop_ok;
  logic [VALUE_W-1:0] pop_sum;
  logic               pop_discard;
  logic [SW:0]        seg_cnt_wide;

  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    logic [VALUE_W-1:0] up_sum, dn_sum;
    logic [CW-1:0]      up_base, dn_base;
    cell_cmd_t          cmd;

    if (i == 0) begin : g_top
      assign up_sum  = new_sum;
      assign up_base = new_base;
      assign cmd     = chain_ctl.top_cmd;
    end else begin : g_inner
      assign up_sum  = cell_sum[i-1];
      assign up_base = cell_base[i-1];
      assign cmd     = chain_ctl.rest_cmd;
    end

    if (i == MAX_SEGMENTS - 1) begin : g_last
      assign dn_sum  = '0;
      assign dn_base = '0;
    end else begin : g_mid
      assign dn_sum  = cell_sum[i+1];
      assign dn_base = cell_base[i+1];
    end

    sscs_cell #(
      .BASE_W (CW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .up_sum  (up_sum),
      .up_base (up_base),
      .dn_sum  (dn_sum),
      .dn_base (dn_base),
      .sum     (cell_sum[i]),
      .base    (cell_base[i])
    );
  end

  assign cnt_m1 = cnt_r - CW'(1);

  sscs_store #(
    .DEPTH (STACK_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (val_r),
    .rd_en   (rd_en),
    .rd_addr (cnt_m1[AW-1:0]),
    .rd_data (rd_data)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State machine outputs.
  always_comb begin
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    commit    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        // A transaction arriving now would start an operation at the same edge.
        cfg_ready = !in_valid;
      end
      ST_EXEC: begin
        commit = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign in_accept = in_valid && !in_stall;
  assign rd_en     = in_accept;

  // Operation datapath, evaluated in the update cycle.
  always_comb begin
    push_total  = {1'b0, cell_sum[0]} + {1'b0, val_r};
    push_open   = push_total > {1'b0, cap_r};
    push_drop   = (push_open && (top_r == SW'(MAX_SEGMENTS - 1)))
                  || (cnt_r >= CW'(STACK_DEPTH));
    pop_ok      = cnt_r > cell_base[0];
    pop_sum     = pop_ok ? (cell_sum[0] - rd_data) : cell_sum[0];
    pop_discard = (pop_sum == '0) && (top_r != '0);

    cnt_nxt     = cnt_r;
    top_nxt     = top_r;
    new_sum     = cell_sum[0];
    new_base    = cell_base[0];
    chain_ctl   = '{top_cmd: CELL_HOLD, rest_cmd: CELL_HOLD};
    wr_en       = 1'b0;
    popped_nxt  = '0;
    status_nxt  = STATUS_OK;
    top_sum_nxt = cell_sum[0];

    if (op_r == OP_PUSH) begin
      if (push_drop) begin
        status_nxt = STATUS_FULL;
      end else begin
        wr_en   = commit;
        cnt_nxt = cnt_r + CW'(1);
        if (push_open) begin
          // A fresh segment enters at the top and the rest move down.
          new_sum   = val_r;
          new_base  = cnt_r;
          top_nxt   = top_r + SW'(1);
          chain_ctl = '{top_cmd: CELL_TAKE_UPPER, rest_cmd: CELL_TAKE_UPPER};
        end else begin
          new_sum   = push_total[VALUE_W-1:0];
          chain_ctl = '{top_cmd: CELL_TAKE_UPPER, rest_cmd: CELL_HOLD};
        end
        top_sum_nxt = new_sum;
      end
    end else begin
      if (pop_ok) begin
        cnt_nxt    = cnt_m1;
        popped_nxt = rd_data;
      end else begin
        status_nxt = STATUS_EMPTY;
      end
      if (pop_discard) begin
        // The emptied segment goes, along with any zero values left in it.
        cnt_nxt     = cell_base[0];
        top_nxt     = top_r - SW'(1);
        chain_ctl   = '{top_cmd: CELL_TAKE_LOWER, rest_cmd: CELL_TAKE_LOWER};
        top_sum_nxt = cell_sum[1];
      end else begin
        new_sum     = pop_sum;
        chain_ctl   = '{top_cmd: CELL_TAKE_UPPER, rest_cmd: CELL_HOLD};
        top_sum_nxt = pop_sum;
      end
    end

    seg_cnt_wide = {1'b0, top_nxt} + (SW+1)'(1);
    seg_cnt_nxt  = SEG_CNT_W'(seg_cnt_wide);

    if (!commit) begin
      cnt_nxt   = cnt_r;
      top_nxt   = top_r;
      chain_ctl = '{top_cmd: CELL_HOLD, rest_cmd: CELL_HOLD};
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign cap_nxt = (cfg_valid && cfg_ready) ? cfg_data : cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      top_r       <= '0;
      cap_r       <= DEF_CAPACITY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      top_r       <= top_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r  <= in_opcode;
      val_r <= in_energy_value;
    end
    if (commit) begin
      popped_r  <= popped_nxt;
      seg_cnt_r <= seg_cnt_nxt;
      top_sum_r <= top_sum_nxt;
      status_r  <= status_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_popped_value  = popped_r;
  assign out_segment_count = seg_cnt_r;
  assign out_top_sum       = top_sum_r;
  assign out_status        = status_r;

  `SSCS_ASSERT_SAME(a_base_within_count, 1'b1, cell_base[0] <= cnt_r)
  `SSCS_ASSERT_SAME(a_count_within_depth, 1'b1, cnt_r <= CW'(STACK_DEPTH))
  `SSCS_ASSERT_NEXT(a_accept_to_exec, in_accept, state_r == ST_EXEC)
  `SSCS_ASSERT_NEXT(a_commit_loads_output, commit, out_valid_r)
  `SSCS_ASSERT_NEXT(a_open_grows_top,
                    commit && (op_r == OP_PUSH) && push_open && !push_drop,
                    top_r == $past(top_r) + SW'(1))

endmodule

### bench/segmented_sum_capped_stack_test.sv
`timescale 1ns / 1ps
// Self-checking bench for segmented_sum_capped_stack: a queue-fed driver, a result
// monitor with its own prediction of the segmented stack, and capacity changes.
// Depends on sscs_pkg and the segmented_sum_capped_stack RTL.
module segmented_sum_capped_stack_test;
  import sscs_pkg::*;

  localparam int STACK_DEPTH    = DEF_STACK_DEPTH;
  localparam int MAX_SEGS       = DEF_MAX_SEGMENTS;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int STALL_NONE     = 0;
  localparam int STALL_HALF     = 1;
  localparam int STALL_HEAVY    = 2;

  typedef struct packed {
    logic               opcode;
    logic [VALUE_W-1:0] value;
  } stack_op_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   popped;
    logic [SEG_CNT_W-1:0] segs;
    logic [VALUE_W-1:0]   top;
    logic [STATUS_W-1:0]  status;
  } reply_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_opcode = OP_PUSH;
  logic [VALUE_W-1:0]   in_energy_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [VALUE_W-1:0]   out_popped_value;
  logic [SEG_CNT_W-1:0] out_segment_count;
  logic [VALUE_W-1:0]   out_top_sum;
  logic [STATUS_W-1:0]  out_status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [VALUE_W-1:0]   cfg_data = '0;

  // Predicted contents of the block.
  logic [VALUE_W-1:0] stored_values [STACK_DEPTH];
  logic [VALUE_W-1:0] segment_sum [MAX_SEGS];
  int                 segment_base [MAX_SEGS];
  int                 stored_count;
  int                 top_index;
  logic [VALUE_W-1:0] capacity_now;

  stack_op_t ops_to_send [$];
  reply_t    replies_due [$];
  reply_t    oldest_reply;
  stack_op_t next_op;

  bit in_taken = 1'b0;
  bit cfg_taken = 1'b0;
  bit pressure_armed = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int stall_mode = STALL_NONE;
  int stretch_left = 0;
  int burst_left = 0;
  int gap_left = 0;
  int idle_cycles = 0;
  int cap_setting = int'(DEF_CAPACITY);
  int ops_sent = 0;
  int replies_checked = 0;
  int full_drops = 0;
  int empty_pops = 0;
  int mismatch_count = 0;

  segmented_sum_capped_stack dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_energy_value   (in_energy_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_popped_value  (out_popped_value),
    .out_segment_count (out_segment_count),
    .out_top_sum       (out_top_sum),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(string field, logic [VALUE_W-1:0] got,
                                 logic [VALUE_W-1:0] want);
    $display("MISMATCH at %0t ns: %s got 0x%h, expected 0x%h", $time, field, got, want);
    mismatch_count++;
  endtask

  // Applies one operation to the predicted stack and returns the result it gives.
  function automatic reply_t apply_stack_op(logic opcode, logic [VALUE_W-1:0] value);
    reply_t             r;
    logic [VALUE_W:0]   trial;
    logic               opens;
    r.popped = '0;
    r.status = STATUS_OK;
    if (opcode == OP_PUSH) begin
      trial = {1'b0, segment_sum[top_index]} + {1'b0, value};
      opens = trial > {1'b0, capacity_now};
      if ((opens && top_index + 1 >= MAX_SEGS) || stored_count >= STACK_DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        if (opens) begin
          top_index++;
          segment_sum[top_index] = '0;
          segment_base[top_index] = stored_count;
        end
        stored_values[stored_count] = value;
        stored_count++;
        segment_sum[top_index] = segment_sum[top_index] + value;
      end
    end else begin
      if (stored_count > segment_base[top_index] && stored_count > 0) begin
        stored_count--;
        r.popped = stored_values[stored_count];
        segment_sum[top_index] = segment_sum[top_index] - r.popped;
      end else begin
        r.status = STATUS_EMPTY;
      end
      // An emptied upper segment is dropped together with any zeros left in it.
      if (segment_sum[top_index] == '0 && top_index > 0) begin
        stored_count = segment_base[top_index];
        top_index--;
      end
    end
    r.segs = SEG_CNT_W'(top_index + 1);
    r.top = segment_sum[top_index];
    return r;
  endfunction

  // Monitor: records accepted transactions, checks results and runs the watchdog.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken = 1'b0;
      cfg_taken = 1'b0;
      stored_count = 0;
      top_index = 0;
      segment_sum[0] = '0;
      segment_base[0] = 0;
      capacity_now = DEF_CAPACITY;
      replies_due.delete();
    end else begin
      in_taken = in_valid && !in_stall;
      cfg_taken = cfg_valid && cfg_ready;
      if (cfg_taken) begin
        capacity_now = cfg_data;
      end
      if (in_taken) begin
        replies_due.push_back(apply_stack_op(in_opcode, in_energy_value));
        if (replies_due[$].status == STATUS_FULL) full_drops++;
        if (replies_due[$].status == STATUS_EMPTY) empty_pops++;
      end
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          report_mismatch("result with nothing pending, top_sum", out_top_sum, '0);
        end else begin
          oldest_reply = replies_due.pop_front();
          replies_checked++;
          if (out_popped_value !== oldest_reply.popped)
            report_mismatch("popped_value", out_popped_value, oldest_reply.popped);
          if (out_segment_count !== oldest_reply.segs)
            report_mismatch("segment_count", VALUE_W'(out_segment_count),
                            VALUE_W'(oldest_reply.segs));
          if (out_top_sum !== oldest_reply.top)
            report_mismatch("top_sum", out_top_sum, oldest_reply.top);
          if (out_status !== oldest_reply.status)
            report_mismatch("status", VALUE_W'(out_status), VALUE_W'(oldest_reply.status));
        end
      end
      if (in_taken || cfg_taken || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Driver: sends queued operations in bursts separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (ops_to_send.size() > 0) begin
        next_op = ops_to_send.pop_front();
        in_opcode <= next_op.opcode;
        in_energy_value <= next_op.value;
        in_valid <= 1'b1;
        ops_sent++;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stretches of differing stall density, plus one long hold-off.
  always @(negedge clk) begin
    if (pressure_armed && !hold_done && hold_left == 0) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (stretch_left == 0) begin
        stall_mode = $urandom_range(2);
        stretch_left = $urandom_range(10, 60);
      end
      stretch_left--;
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_HALF: out_stall <= ($urandom_range(1) == 1);
        default:    out_stall <= ($urandom_range(3) != 0);
      endcase
    end
  end

  task automatic queue_op(logic opcode, int value);
    stack_op_t op;
    op.opcode = opcode;
    op.value = VALUE_W'(value);
    ops_to_send.push_back(op);
  endtask

  // Random mix sized around the current capacity so that segments open and close.
  task automatic queue_random(int count, int push_pct);
    stack_op_t op;
    for (int i = 0; i < count; i++) begin
      op.opcode = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
      case ($urandom_range(9))
        0:       op.value = '0;
        1:       op.value = '1;
        2:       op.value = VALUE_W'(cap_setting);
        3:       op.value = VALUE_W'(cap_setting + 1);
        4, 5:    op.value = VALUE_W'($urandom_range(65535));
        default: op.value = VALUE_W'($urandom_range(cap_setting / 4 + 1));
      endcase
      ops_to_send.push_back(op);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (ops_to_send.size() != 0 || in_valid || replies_due.size() != 0);
  endtask

  task automatic set_capacity(int value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= VALUE_W'(value);
    do @(negedge clk);
    while (!cfg_taken);
    cfg_valid <= 1'b0;
    cap_setting = value;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset capacity: empty pops, an oversized first push, zero-sum discards.
    queue_op(OP_POP, 'h5a5a);
    queue_op(OP_PUSH, 1001);
    queue_op(OP_POP, 0);
    queue_op(OP_PUSH, 65535);
    queue_op(OP_PUSH, 0);
    queue_op(OP_POP, 0);
    queue_op(OP_POP, 0);
    queue_op(OP_POP, 'hffff);
    queue_op(OP_PUSH, 1000);
    queue_op(OP_PUSH, 1);
    queue_random(60, 60);

    // Zero capacity: every non-zero push opens a segment until the table is full.
    set_capacity(0);
    for (int i = 0; i < MAX_SEGS; i++) queue_op(OP_PUSH, 1);
    queue_random(40, 30);

    // Largest capacity: empty the stack, then fill the store past its depth
    // while the receiver holds off for a long stretch.
    set_capacity(65535);
    pressure_armed = 1'b1;
    for (int i = 0; i <= stored_count; i++) queue_op(OP_POP, $urandom_range(65535));
    for (int i = 0; i < STACK_DEPTH + 2; i++) queue_op(OP_PUSH, $urandom_range(255));
    queue_random(60, 35);

    // Capacity dropped below the sum now on top.
    set_capacity(100);
    queue_random(80, 55);

    set_capacity($urandom_range(1, 4000));
    queue_random(100, 55);

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Run covered %0d operations over five capacity settings, %0d results checked.",
             ops_sent, replies_checked);
    $display("Refused pushes: %0d, pops on an empty segment: %0d.", full_drops, empty_pops);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
